### src/bbn_pkg.sv
// ----------------------------------------------------------------------------
// bbn_pkg
// Shared types and constants of the bounding-box normalizer: transaction
// structs, request and status codes, controller states and command bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package bbn_pkg;

    // request codes
    localparam logic [1:0] REQ_CLEAR     = 2'd0;
    localparam logic [1:0] REQ_ADD       = 2'd1;
    localparam logic [1:0] REQ_MAP_POINT = 2'd2;
    localparam logic [1:0] REQ_MAP_DIR   = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_AXIS = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;

    // up axis codes
    localparam logic [1:0] AXIS_Y_UP     = 2'd1;
    localparam logic [1:0] AXIS_Z_UP     = 2'd2;

    localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
    localparam logic [31:0] S32_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN      = 32'h8000_0000;

    // radix-2 divider: 33 quotient bits, one per cycle
    localparam int          DIV_CNT_W    = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd32;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         status;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [31:0]        largest_extent;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOUNDS,
        S_DERIVE,
        S_SETUP,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic upd_bounds;
        logic derive;
        logic setup;
        logic div_load;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
    } dp_stat_t;

endpackage

`default_nettype wire

### src/bbn_div.sv
// ----------------------------------------------------------------------------
// bbn_div
// Three-lane restoring radix-2 divider. Each lane divides |diff| * 2^30 by a
// shared 32-bit divisor, one quotient bit per step, and flags quotients that
// cannot fit in 33 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bbn_div (
    input  wire logic              clk,
    input  wire logic              load,
    input  wire logic              step,
    input  wire logic [2:0][32:0]  diff,
    input  wire logic [31:0]       divisor,
    output logic      [2:0][32:0]  quot,
    output logic      [2:0]        neg,
    output logic      [2:0]        ovf
);
    import bbn_pkg::*;

    logic [2:0][31:0] rem_reg, rem_next;
    logic [2:0][32:0] qf_reg, qf_next;
    logic [2:0]       neg_reg, neg_next;
    logic [2:0]       ovf_reg, ovf_next;

    logic [2:0][32:0] mag;
    logic [2:0][32:0] trial;
    logic [2:0][32:0] trial_sub;

    always_comb
    begin
        rem_next = rem_reg;
        qf_next  = qf_reg;
        neg_next = neg_reg;
        ovf_next = ovf_reg;
        for (int l = 0; l < 3; l++)
        begin
            mag[l]       = diff[l][32] ? (33'd0 - diff[l]) : diff[l];
            // shifted remainder with the next dividend bit brought in
            trial[l]     = {rem_reg[l], qf_reg[l][32]};
            trial_sub[l] = trial[l] - {1'b0, divisor};
            if (load)
            begin
                neg_next[l] = diff[l][32];
                // dividend bits above bit 32 already reach the divisor
                ovf_next[l] = {2'b00, mag[l][32:3]} >= divisor;
                rem_next[l] = {2'b00, mag[l][32:3]};
                qf_next[l]  = {mag[l][2:0], 30'd0};
            end
            else if (step)
            begin
                if (trial[l] >= {1'b0, divisor})
                begin
                    rem_next[l] = trial_sub[l][31:0];
                    qf_next[l]  = {qf_reg[l][31:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = trial[l][31:0];
                    qf_next[l]  = {qf_reg[l][31:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qf_reg  <= qf_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
    end

    assign quot = qf_reg;
    assign neg  = neg_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

### src/bbn_dp.sv
// ----------------------------------------------------------------------------
// bbn_dp
// Datapath: input and configuration registers, per-axis bounds, center and
// extent, the divider lanes, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbn_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bbn_pkg::dp_cmd_t    cmd,
    output bbn_pkg::dp_stat_t        stat,
    input  wire bbn_pkg::in_item_t   in_data,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_data,
    output bbn_pkg::out_item_t       out_data
);
    import bbn_pkg::*;

    in_item_t         in_reg, in_next;
    logic [1:0]       up_axis_reg, up_axis_next;
    logic [2:0][31:0] low_reg, low_next;
    logic [2:0][31:0] high_reg, high_next;
    logic             seen_reg, seen_next;
    logic [2:0][31:0] center_reg, center_next;
    logic [2:0][31:0] extent_reg, extent_next;
    logic [31:0]      ext_reg, ext_next;
    logic [2:0][32:0] diff_reg, diff_next;
    logic             need_div_reg, need_div_next;
    out_item_t        out_reg, out_next;

    logic [2:0][31:0] coord;
    logic [2:0][32:0] sum;
    logic [31:0]      ext_xy;
    logic [31:0]      divisor;
    logic [2:0][32:0] quot;
    logic [2:0]       q_neg;
    logic [2:0]       q_ovf;
    logic [2:0][31:0] res;
    logic [1:0]       status_c;
    logic             axis_ok;
    logic             swap;

    assign coord[0] = in_reg.coord_x;
    assign coord[1] = in_reg.coord_y;
    assign coord[2] = in_reg.coord_z;

    assign axis_ok = (up_axis_reg == AXIS_Y_UP) || (up_axis_reg == AXIS_Z_UP);
    assign divisor = (ext_reg == 32'd0) ? ONE_Q16 : ext_reg;

    bbn_div u_div (
        .clk     (clk),
        .load    (cmd.div_load),
        .step    (cmd.div_step),
        .diff    (diff_reg),
        .divisor (divisor),
        .quot    (quot),
        .neg     (q_neg),
        .ovf     (q_ovf)
    );

    always_comb
    begin
        in_next       = in_reg;
        up_axis_next  = up_axis_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        seen_next     = seen_reg;
        center_next   = center_reg;
        extent_next   = extent_reg;
        ext_next      = ext_reg;
        diff_next     = diff_reg;
        need_div_next = need_div_reg;
        out_next      = out_reg;

        if (cmd.load_in)
        begin
            in_next = in_data;
        end
        if (cfg_we)
        begin
            up_axis_next = cfg_data;
        end

        if (cmd.upd_bounds)
        begin
            if (in_reg.req_type == REQ_CLEAR)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    low_next[l]  = S32_MAX;
                    high_next[l] = S32_MIN;
                end
                seen_next = 1'b0;
            end
            else if (in_reg.req_type == REQ_ADD)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if ($signed(coord[l]) < $signed(low_reg[l]))
                        low_next[l] = coord[l];
                    if ($signed(coord[l]) > $signed(high_reg[l]))
                        high_next[l] = coord[l];
                end
                seen_next = 1'b1;
            end
        end

        for (int l = 0; l < 3; l++)
        begin
            sum[l] = {low_reg[l][31], low_reg[l]} + {high_reg[l][31], high_reg[l]};
        end
        if (cmd.derive)
        begin
            for (int l = 0; l < 3; l++)
            begin
                center_next[l] = sum[l][32:1];
                extent_next[l] = high_reg[l] - low_reg[l];
            end
        end

        ext_xy = (extent_reg[1] > extent_reg[0]) ? extent_reg[1] : extent_reg[0];
        if (cmd.setup)
        begin
            ext_next = (extent_reg[2] > ext_xy) ? extent_reg[2] : ext_xy;
            for (int l = 0; l < 3; l++)
            begin
                diff_next[l] = {coord[l][31], coord[l]} - {center_reg[l][31], center_reg[l]};
            end
            need_div_next = (in_reg.req_type == REQ_MAP_POINT) && axis_ok && seen_reg;
        end

        // result assembly
        if (in_reg.req_type == REQ_MAP_POINT)
        begin
            if (!axis_ok)
                status_c = STAT_BAD_AXIS;
            else if (!seen_reg)
                status_c = STAT_EMPTY;
            else
                status_c = STAT_OK;
        end
        else
        begin
            status_c = STAT_OK;
        end

        for (int l = 0; l < 3; l++)
        begin
            if (need_div_reg)
            begin
                if (q_neg[l])
                begin
                    if (q_ovf[l] || (quot[l] > 33'h0_8000_0000))
                        res[l] = S32_MIN;
                    else
                        res[l] = 32'd0 - quot[l][31:0];
                end
                else
                begin
                    if (q_ovf[l] || (quot[l] > 33'h0_7FFF_FFFF))
                        res[l] = S32_MAX;
                    else
                        res[l] = quot[l][31:0];
                end
            end
            else if (in_reg.req_type == REQ_MAP_DIR)
            begin
                res[l] = coord[l];
            end
            else
            begin
                res[l] = 32'd0;
            end
        end

        swap = ((in_reg.req_type == REQ_MAP_POINT) || (in_reg.req_type == REQ_MAP_DIR))
               && (status_c == STAT_OK) && (up_axis_reg == AXIS_Z_UP);

        if (cmd.finish)
        begin
            if (swap)
            begin
                out_next.out_x = (res[0] == S32_MIN) ? S32_MAX : (32'd0 - res[0]);
                out_next.out_y = res[2];
                out_next.out_z = res[1];
            end
            else
            begin
                out_next.out_x = res[0];
                out_next.out_y = res[1];
                out_next.out_z = res[2];
            end
            out_next.status         = status_c;
            out_next.center_x       = seen_reg ? center_reg[0] : 32'd0;
            out_next.center_y       = seen_reg ? center_reg[1] : 32'd0;
            out_next.center_z       = seen_reg ? center_reg[2] : 32'd0;
            out_next.largest_extent = seen_reg ? ext_reg : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_axis_reg <= AXIS_Y_UP;
            low_reg     <= {3{S32_MAX}};
            high_reg    <= {3{S32_MIN}};
            seen_reg    <= 1'b0;
        end
        else
        begin
            up_axis_reg <= up_axis_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            seen_reg    <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        center_reg   <= center_next;
        extent_reg   <= extent_next;
        ext_reg      <= ext_next;
        diff_reg     <= diff_next;
        need_div_reg <= need_div_next;
        out_reg      <= out_next;
    end

    assign stat.need_div = need_div_next;
    assign out_data      = out_reg;

endmodule

`default_nettype wire

### src/bbn_ctrl.sv
// ----------------------------------------------------------------------------
// bbn_ctrl
// Controller: sequences one transaction through bounds update, center and
// extent, division when needed and result load, and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module bbn_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire bbn_pkg::dp_stat_t stat,
    output bbn_pkg::dp_cmd_t       cmd
);
    import bbn_pkg::*;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_stall       = 1'b1;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_BOUNDS;
                end
            end
            S_BOUNDS:
            begin
                cmd.upd_bounds = 1'b1;
                state_next     = S_DERIVE;
            end
            S_DERIVE:
            begin
                cmd.derive = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = stat.need_div ? S_DIV_INIT : S_DONE;
            end
            S_DIV_INIT:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && out_stall))
        else $error("result register loaded while a result is stalled");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished transaction not presented");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_BOUNDS))
        else $error("accepted transaction did not start");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= DIV_LAST))
        else $error("divider step count out of range");

endmodule

`default_nettype wire

### src/bounding_box_normalizer_top.sv
// An accepted transaction goes through the bounds, derive and setup states
// before its result is loaded. A map point request with a valid up axis and
// a non-empty box also goes through the radix-2 divider: a load step and then
// 33 steps that each produce one quotient bit for all three axes at once. One
// transaction is in flight at a time. The next one is accepted as soon as the
// previous result sits in the output register, even while that result is still
// stalled; a new result then waits in the done state until the last is taken.
// The up_axis register is written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
// bounding_box_normalizer_top
// Axis-aligned bounding-box normalizer on signed Q16.16 coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module bounding_box_normalizer_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire bbn_pkg::in_item_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output bbn_pkg::out_item_t       out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_data
);
    import bbn_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    bbn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bbn_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (in_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

### sim/bbn_checker.sv
// ----------------------------------------------------------------------------
// bbn_checker
// Watches the request, result and up-axis channels of the bounding-box
// normalizer, predicts every result from its own copy of the box and the
// up axis, and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module bbn_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  bbn_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  bbn_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_data,
    output int                 mismatches,
    output int                 pending,
    output int                 checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import bbn_pkg::*;

    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    bit                 box_seen;
    logic [1:0]         up_axis_copy;
    out_item_t          expected_results [$];
    int                 reports;

    function automatic void clear_box();
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = S32_MAX;
            box_hi[a] = S32_MIN;
        end
        box_seen = 1'b0;
    endfunction

    // signed Q16.16 offset over unsigned extent -> Q2.30, truncated, saturated
    function automatic logic [31:0] scale_q30(longint diff, longint unsigned divisor);
        longint unsigned mag;
        longint unsigned quo;
        mag = (diff < 0) ? -diff : diff;
        quo = (mag << 30) / divisor;
        if (diff < 0)
        begin
            if (quo > 64'h8000_0000)
                quo = 64'h8000_0000;
            quo = -quo;
        end
        else if (quo > 64'h7FFF_FFFF)
            quo = 64'h7FFF_FFFF;
        return quo[31:0];
    endfunction

    // updates the box and returns the result of one request
    function automatic out_item_t normalize_item(in_item_t it);
        logic signed [31:0] pos [3];
        logic signed [31:0] res [3];
        logic signed [31:0] tmp;
        longint             ctr [3];
        longint unsigned    ext;
        longint unsigned    side;
        logic [1:0]         st;
        out_item_t          o;

        pos[0] = it.coord_x;
        pos[1] = it.coord_y;
        pos[2] = it.coord_z;

        if (it.req_type == REQ_CLEAR)
            clear_box();
        else if (it.req_type == REQ_ADD)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (pos[a] < box_lo[a])
                    box_lo[a] = pos[a];
                if (pos[a] > box_hi[a])
                    box_hi[a] = pos[a];
            end
            box_seen = 1'b1;
        end

        ext = 0;
        for (int a = 0; a < 3; a++)
        begin
            ctr[a] = 0;
            res[a] = '0;
            if (box_seen)
            begin
                side = longint'(box_hi[a]) - longint'(box_lo[a]);
                if (side > ext)
                    ext = side;
                ctr[a] = (longint'(box_lo[a]) + longint'(box_hi[a])) >>> 1;
            end
        end

        st = STAT_OK;
        if (it.req_type == REQ_MAP_POINT)
        begin
            if (up_axis_copy != AXIS_Y_UP && up_axis_copy != AXIS_Z_UP)
                st = STAT_BAD_AXIS;
            else if (!box_seen)
                st = STAT_EMPTY;
            else
                for (int a = 0; a < 3; a++)
                    res[a] = scale_q30(longint'(pos[a]) - ctr[a],
                                       (ext != 0) ? ext : 64'(ONE_Q16));
        end
        else if (it.req_type == REQ_MAP_DIR)
            res = pos;

        // Z-up: (x, y, z) -> (-x, z, y), negation of the most negative saturates
        if ((it.req_type == REQ_MAP_POINT || it.req_type == REQ_MAP_DIR) &&
            st == STAT_OK && up_axis_copy == AXIS_Z_UP)
        begin
            tmp    = res[1];
            res[0] = (res[0] == S32_MIN) ? S32_MAX : -res[0];
            res[1] = res[2];
            res[2] = tmp;
        end

        o.out_x          = res[0];
        o.out_y          = res[1];
        o.out_z          = res[2];
        o.status         = st;
        o.center_x       = ctr[0][31:0];
        o.center_y       = ctr[1][31:0];
        o.center_z       = ctr[2][31:0];
        o.largest_extent = ext[31:0];
        return o;
    endfunction

    function automatic string fmt_item(out_item_t v);
        return $sformatf("out=%h/%h/%h st=%0d ctr=%h/%h/%h ext=%h",
                         v.out_x, v.out_y, v.out_z, v.status,
                         v.center_x, v.center_y, v.center_z, v.largest_extent);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            clear_box();
            up_axis_copy = AXIS_Y_UP;
            expected_results.delete();
            mismatches = 0;
            pending    = 0;
            checked    = 0;
            reports    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                up_axis_copy = cfg_data;

            if (in_valid && !in_stall)
                expected_results.push_back(normalize_item(in_data));

            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (reports < 10)
                        $display("%0t: result with nothing expected: %s",
                                 $realtime, fmt_item(out_data));
                    reports++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    if (out_data.out_x          !== want.out_x    ||
                        out_data.out_y          !== want.out_y    ||
                        out_data.out_z          !== want.out_z    ||
                        out_data.status         !== want.status   ||
                        out_data.center_x       !== want.center_x ||
                        out_data.center_y       !== want.center_y ||
                        out_data.center_z       !== want.center_z ||
                        out_data.largest_extent !== want.largest_extent)
                    begin
                        mismatches++;
                        if (reports < 10)
                        begin
                            $display("%0t: result %0d mismatch", $realtime, checked);
                            $display("    expected %s", fmt_item(want));
                            $display("    actual   %s", fmt_item(out_data));
                        end
                        reports++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

### sim/bounding_box_normalizer_top_test.sv
// ----------------------------------------------------------------------------
// bounding_box_normalizer_top_test
// Drives directed and random clear / add / map requests into the normalizer
// under every up-axis setting, with random idling on both channels and one
// long output hold-off; bbn_checker predicts and checks the results.
// ----------------------------------------------------------------------------
module bounding_box_normalizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bbn_pkg::*;

    localparam int         LIMIT       = 300000;
    localparam int         HOLD_CYCLES = 400;
    localparam int         IDLE_PCT    = 8;
    localparam int         PHASE_ITEMS = 106;
    localparam int         NUM_PHASES  = 8;
    localparam logic [1:0] AXIS_NONE   = 2'd0;
    localparam logic [1:0] AXIS_RSVD   = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;

    int mismatches;
    int pending;
    int checked;
    int cycle_count = 0;
    int span_bits;
    int req_count [4];
    int hold_left;
    bit quiet;
    bit hold_req;
    bit hold_done;

    logic [1:0] phase_axis [NUM_PHASES] = '{AXIS_Y_UP, AXIS_Z_UP, AXIS_NONE, AXIS_Z_UP,
                                            AXIS_Y_UP, AXIS_RSVD, AXIS_Z_UP, AXIS_Y_UP};

    bounding_box_normalizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bbn_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, pending);
            $display("bounding_box_normalizer_top verification failed");
            $finish;
        end
    end

    // result side: random stall, quiet stretches, one long hold-off
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    function automatic in_item_t make_item(logic [1:0] kind, logic [31:0] x,
                                           logic [31:0] y, logic [31:0] z);
        in_item_t it;
        it.req_type = kind;
        it.coord_x  = x;
        it.coord_y  = y;
        it.coord_z  = z;
        return it;
    endfunction

    // mostly coordinates within the current span, some extremes and full range
    function automatic logic [31:0] random_coord();
        int r;
        r = $urandom;
        case ($urandom_range(0, 15))
            0:       return S32_MIN;
            1:       return S32_MAX;
            2:       return '0;
            3, 4:    return r;
            default: return r >>> (32 - span_bits);
        endcase
    endfunction

    function automatic in_item_t random_request();
        int         pick;
        logic [1:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            kind      = REQ_CLEAR;
            span_bits = $urandom_range(2, 32);
        end
        else if (pick < 40)
            kind = REQ_ADD;
        else if (pick < 82)
            kind = REQ_MAP_POINT;
        else
            kind = REQ_MAP_DIR;
        return make_item(kind, random_coord(), random_coord(), random_coord());
    endfunction

    // returns right after the accepting edge; valid stays up for a follow-on item
    task automatic send_item(in_item_t it);
        @(negedge clk);
        if (!quiet)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        req_count[it.req_type]++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_up_axis(logic [1:0] axis);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= axis;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        span_bits = 20;
        req_count = '{0, 0, 0, 0};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Y up from reset: empty box, single vertex, full-range box, saturation
        send_item(make_item(REQ_MAP_POINT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        send_item(make_item(REQ_MAP_DIR, S32_MIN, S32_MAX, 32'h1234_5678));
        send_item(make_item(REQ_ADD, 32'h0, 32'h0, 32'h0));
        send_item(make_item(REQ_MAP_POINT, 32'h0001_0000, 32'hFFFF_0000, 32'h5));
        send_item(make_item(REQ_MAP_POINT, S32_MAX, S32_MIN, 32'h0));
        send_item(make_item(REQ_ADD, S32_MIN, S32_MAX, S32_MIN));
        send_item(make_item(REQ_ADD, S32_MAX, S32_MIN, S32_MAX));
        send_item(make_item(REQ_MAP_POINT, S32_MAX, S32_MIN, 32'h0));
        send_item(make_item(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(REQ_ADD, 32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000));
        send_item(make_item(REQ_ADD, 32'hFFFF_0000, 32'h0004_0000, 32'h0005_0000));
        send_item(make_item(REQ_MAP_POINT, 32'h0001_8000, 32'h0, 32'h0000_7FFF));

        // Z up: swap and negation saturation
        settle();
        write_up_axis(AXIS_Z_UP);
        send_item(make_item(REQ_MAP_POINT, S32_MIN, 32'h0001_0000, 32'h0002_0000));
        send_item(make_item(REQ_MAP_POINT, S32_MAX, 32'h0001_0000, 32'hFFFF_0000));
        send_item(make_item(REQ_MAP_DIR, S32_MIN, 32'h1, 32'hFFFF_FFFF));
        send_item(make_item(REQ_MAP_DIR, S32_MAX, 32'h5555_5555, 32'hAAAA_AAAA));
        send_item(make_item(REQ_ADD, 32'h0010_0000, 32'hFFF0_0000, 32'h0));
        send_item(make_item(REQ_MAP_POINT, 32'h0004_0000, 32'h0, 32'h0002_0000));
        send_item(make_item(REQ_CLEAR, 32'h0, 32'h0, 32'h0));
        send_item(make_item(REQ_MAP_POINT, 32'h0, 32'h0, 32'h0));

        // invalid axes: axis error wins over empty box, directions pass through
        settle();
        write_up_axis(AXIS_NONE);
        send_item(make_item(REQ_MAP_POINT, 32'h0, 32'h0, 32'h0));
        send_item(make_item(REQ_ADD, 32'h0005_0000, 32'h0006_0000, 32'h0007_0000));
        send_item(make_item(REQ_MAP_POINT, 32'h0005_0000, 32'h0006_0000, 32'h0));
        send_item(make_item(REQ_MAP_DIR, S32_MIN, 32'h0, S32_MAX));
        settle();
        write_up_axis(AXIS_RSVD);
        send_item(make_item(REQ_MAP_POINT, 32'h0001_0000, 32'h0, 32'h0));
        send_item(make_item(REQ_MAP_DIR, 32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0));
        send_item(make_item(REQ_CLEAR, 32'h0, 32'h0, 32'h0));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            write_up_axis(phase_axis[p]);
            hold_req = (p == 1);
            quiet    = (p == 4);
            repeat (PHASE_ITEMS)
                send_item(random_request());
        end
        quiet = 1'b0;

        settle();
        repeat (60) @(negedge clk);

        $display("Covered %0d clears, %0d vertices, %0d point and %0d direction maps",
                 req_count[REQ_CLEAR], req_count[REQ_ADD],
                 req_count[REQ_MAP_POINT], req_count[REQ_MAP_DIR]);
        $display("under all four up-axis codes; %0d results checked, %0d mismatches",
                 checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("bounding_box_normalizer_top verification clean");
        else
            $display("bounding_box_normalizer_top verification failed");
        $finish;
    end

endmodule
